// File: rtl/core/c_source_number_literal_scanner_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the number literal scanner
// Shared property forms; each expects a signal named clock and reset in scope.
// ----------------------------------------------------------------------------
`ifndef C_SOURCE_NUMBER_LITERAL_SCANNER_UNIT_DEFINES_SVH
`define C_SOURCE_NUMBER_LITERAL_SCANNER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CNLS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define CNLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/cnls_pkg.sv
// ----------------------------------------------------------------------------
// Number literal scanner package
// Constants, command and result types shared by the scanner modules.
// ----------------------------------------------------------------------------
package cnls_pkg;

   // Literal buffer depth and derived widths.
   localparam int LIT_MAX = 32;
   localparam int IDX_W   = $clog2(LIT_MAX);
   localparam int LEN_W   = $clog2(LIT_MAX + 1);

   // Command queue depth between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Characters the scanner looks for.
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_DOT       = 8'h2E;
   localparam logic [7:0] CH_ZERO      = 8'h30;
   localparam logic [7:0] CH_NINE      = 8'h39;

   // Result kinds.
   localparam logic KIND_LITERAL = 1'b0;
   localparam logic KIND_ERROR   = 1'b1;

   // Work handed from the front to the back.
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_FLUSH = 2'd1,
      CMD_ERROR = 2'd2
   } cmd_op_type;

   // addr is the buffer slot for a write and the run length for a flush.
   typedef struct packed {
      cmd_op_type       op;
      logic [7:0]       data;
      logic [LEN_W-1:0] addr;
      logic             trunc;
   } cmd_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       kind;
      logic       last;
      logic       truncated;
   } rsp_payload_type;

endpackage

// File: rtl/core/cnls_if.sv
// ----------------------------------------------------------------------------
// Number literal scanner channels
// Valid/ready channels for source text bytes and for result words.
// ----------------------------------------------------------------------------
interface cnls_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       restart;

   modport source (output valid, output ch, output restart, input ready);
   modport sink   (input valid, input ch, input restart, output ready);
endinterface

interface cnls_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       kind;
   logic       last;
   logic       truncated;

   modport source (output valid, output out_byte, output kind, output last,
                   output truncated, input ready);
   modport sink   (input valid, input out_byte, input kind, input last,
                   input truncated, output ready);
endinterface

// File: rtl/core/c_source_number_literal_scanner_unit.sv
// ----------------------------------------------------------------------------
// C source number literal scanner
// With an idle back end and a ready result side, the first word of a run goes through the
// command queue, the flush, a buffer read and an emit into the output register; an error word
// goes through the queue and straight into the output register. Throughput: one source byte
// per cycle while the queue has room; a run is a flush, then a read and an emit per word.
// Reset is synchronous and active high: code mode, empty queue, no pending word, buffer kept.
// ----------------------------------------------------------------------------
module c_source_number_literal_scanner_unit (
   input  logic              clock,
   input  logic              reset,
   cnls_req_if.sink          req_chan,
   cnls_rsp_if.source        rsp_chan
);

   // The front end tracks the scanner mode, the previous byte and the length of
   // the open literal. Every byte it accepts turns into at most one command: a
   // write of the byte into a buffer slot, a flush of a finished literal, or an
   // error report for a byte outside the seven-bit alphabet.
   //
   // The command queue sits between the two halves so that the front end keeps
   // taking text while the back end replays a literal, and the back end keeps
   // draining while the text source pauses. While a run is still being replayed
   // the queue fills after two commands and the front end stops taking text, so
   // new results wait behind whatever replay is left.
   //
   // The back end owns the literal buffer. Because commands arrive in order, the
   // writes of a new literal can never overtake the replay of the previous one.

   cnls_pkg::cmd_type         front_cmd;
   cnls_pkg::cmd_type         head_cmd;
   cnls_pkg::rsp_payload_type rsp_word;
   logic                      cmd_push;
   logic                      cmd_pop;
   logic                      queue_empty;
   logic                      queue_full;

   cnls_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_ready   (req_chan.ready),
      .req_ch      (req_chan.ch),
      .req_restart (req_chan.restart),
      .queue_full  (queue_full),
      .cmd_push    (cmd_push),
      .cmd         (front_cmd)
   );

   cnls_cmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (cmd_push),
      .push_cmd (front_cmd),
      .pop      (cmd_pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   cnls_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .head_cmd    (head_cmd),
      .pop         (cmd_pop),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .rsp_word    (rsp_word)
   );

   // The output word is held in the back end's register until it is taken.
   assign rsp_chan.out_byte  = rsp_word.out_byte;
   assign rsp_chan.kind      = rsp_word.kind;
   assign rsp_chan.last      = rsp_word.last;
   assign rsp_chan.truncated = rsp_word.truncated;

endmodule

// File: rtl/core/cnls_front.sv
// ----------------------------------------------------------------------------
// Number literal scanner front end
// Runs the six-mode scanner on each byte and issues buffer commands.
// ----------------------------------------------------------------------------
module cnls_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_ch,
   input  logic                   req_restart,
   input  logic                   queue_full,
   output logic                   cmd_push,
   output cnls_pkg::cmd_type      cmd
);

   typedef enum logic [5:0] {
      MODE_CODE   = 6'b000001,
      MODE_STRING = 6'b000010,
      MODE_LINE   = 6'b000100,
      MODE_BLOCK  = 6'b001000,
      MODE_NUMBER = 6'b010000,
      MODE_HALT   = 6'b100000
   } mode_type;

   mode_type                   mode_ff, mode_in, mode_v, mode_n;
   logic [7:0]                 prev_ff, prev_in, prev_v;
   logic [cnls_pkg::LEN_W-1:0] len_ff, len_in, len_v, len_n;
   logic                       ovf_ff, ovf_in, ovf_v, ovf_n;
   logic                       dot_ff, dot_in, dot_v, dot_n;
   logic                       accept;
   logic                       is_digit;
   logic                       quote_open;

   assign req_ready  = !queue_full;
   assign accept     = req_valid && req_ready;
   assign is_digit   = (req_ch >= cnls_pkg::CH_ZERO) && (req_ch <= cnls_pkg::CH_NINE);

   // A restart clears the scanner before the byte is looked at.
   assign mode_v = req_restart ? MODE_CODE : mode_ff;
   assign prev_v = req_restart ? 8'd0 : prev_ff;
   assign len_v  = req_restart ? '0 : len_ff;
   assign ovf_v  = req_restart ? 1'b0 : ovf_ff;
   assign dot_v  = req_restart ? 1'b0 : dot_ff;

   assign quote_open = (req_ch == cnls_pkg::CH_DQUOTE) &&
                       (prev_v != cnls_pkg::CH_BACKSLASH) &&
                       (prev_v != cnls_pkg::CH_SQUOTE);

   always_comb begin
      mode_in  = mode_ff;
      prev_in  = prev_ff;
      len_in   = len_ff;
      ovf_in   = ovf_ff;
      dot_in   = dot_ff;
      mode_n   = mode_v;
      len_n    = len_v;
      ovf_n    = ovf_v;
      dot_n    = dot_v;
      cmd_push = 1'b0;
      cmd      = '0;
      if (accept) begin
         mode_in = mode_v;
         prev_in = prev_v;
         len_in  = len_v;
         ovf_in  = ovf_v;
         dot_in  = dot_v;
         if (mode_v == MODE_HALT) begin
            // Halted: bytes are ignored until the next restart.
         end else if (req_ch[7]) begin
            cmd_push  = 1'b1;
            cmd.op    = cnls_pkg::CMD_ERROR;
            cmd.data  = req_ch;
            mode_in   = MODE_HALT;
            len_in    = '0;
            ovf_in    = 1'b0;
         end else begin
            unique case (mode_v)
               MODE_CODE: begin
                  if (quote_open) begin
                     mode_n = MODE_STRING;
                  end else if (req_ch == cnls_pkg::CH_SLASH &&
                               prev_v == cnls_pkg::CH_SLASH) begin
                     mode_n = MODE_LINE;
                  end else if (req_ch == cnls_pkg::CH_STAR &&
                               prev_v == cnls_pkg::CH_SLASH) begin
                     mode_n = MODE_BLOCK;
                  end else if ((req_ch == cnls_pkg::CH_DOT &&
                                prev_v != cnls_pkg::CH_DOT) || is_digit) begin
                     mode_n = MODE_NUMBER;
                     len_n  = '0;
                     ovf_n  = 1'b0;
                     dot_n  = 1'b0;
                  end
               end
               MODE_STRING: begin
                  if (quote_open) begin
                     mode_n = MODE_CODE;
                  end
               end
               MODE_LINE: begin
                  if (req_ch == cnls_pkg::CH_NEWLINE) begin
                     mode_n = MODE_CODE;
                  end
               end
               MODE_BLOCK: begin
                  if (req_ch == cnls_pkg::CH_SLASH && prev_v == cnls_pkg::CH_STAR) begin
                     mode_n = MODE_CODE;
                  end
               end
               MODE_NUMBER: begin
                  if (!is_digit) begin
                     mode_n = MODE_CODE;
                     // A literal that is only a dot is dropped without a run.
                     if (len_v != '0 && !(len_v == cnls_pkg::LEN_W'(1) && dot_v)) begin
                        cmd_push  = 1'b1;
                        cmd.op    = cnls_pkg::CMD_FLUSH;
                        cmd.addr  = len_v;
                        cmd.trunc = ovf_v;
                     end
                     len_n = '0;
                     ovf_n = 1'b0;
                  end
               end
               MODE_HALT: begin
               end
               default: begin
               end
            endcase
            if (mode_n == MODE_NUMBER) begin
               if (len_n < cnls_pkg::LEN_W'(cnls_pkg::LIT_MAX)) begin
                  cmd_push = 1'b1;
                  cmd.op   = cnls_pkg::CMD_WRITE;
                  cmd.data = req_ch;
                  cmd.addr = len_n;
                  if (len_n == '0) begin
                     dot_n = (req_ch == cnls_pkg::CH_DOT);
                  end
                  len_n = len_n + cnls_pkg::LEN_W'(1);
               end else begin
                  ovf_n = 1'b1;
               end
            end
            mode_in = mode_n;
            len_in  = len_n;
            ovf_in  = ovf_n;
            dot_in  = dot_n;
            prev_in = req_ch;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_CODE;
         prev_ff <= 8'd0;
         len_ff  <= '0;
         ovf_ff  <= 1'b0;
         dot_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         prev_ff <= prev_in;
         len_ff  <= len_in;
         ovf_ff  <= ovf_in;
         dot_ff  <= dot_in;
      end
   end

endmodule

// File: rtl/core/cnls_cmd_queue.sv
// ----------------------------------------------------------------------------
// Number literal scanner command queue
// Short FIFO that lets the front and back stall independently.
// ----------------------------------------------------------------------------
module cnls_cmd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cnls_pkg::cmd_type   push_cmd,
   input  logic                pop,
   output cnls_pkg::cmd_type   head_cmd,
   output logic                empty,
   output logic                full
);

   cnls_pkg::cmd_type            slot_ff [cnls_pkg::QUEUE_DEPTH];
   logic [cnls_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cnls_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cnls_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                         do_push, do_pop;

   localparam logic [cnls_pkg::QPTR_W-1:0] LastSlot =
      cnls_pkg::QPTR_W'(cnls_pkg::QUEUE_DEPTH - 1);

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == cnls_pkg::QCNT_W'(cnls_pkg::QUEUE_DEPTH));
   assign head_cmd = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastSlot) ? '0 : wr_ptr_ff + cnls_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastSlot) ? '0 : rd_ptr_ff + cnls_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + cnls_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - cnls_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/core/cnls_back.sv
// ----------------------------------------------------------------------------
// Number literal scanner back end
// Owns the literal buffer, replays finished literals and drives results.
// ----------------------------------------------------------------------------
`include "c_source_number_literal_scanner_unit_defines.svh"

module cnls_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      queue_empty,
   input  cnls_pkg::cmd_type         head_cmd,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cnls_pkg::rsp_payload_type rsp_word
);

   typedef enum logic [2:0] {
      BK_IDLE = 3'b001,
      BK_READ = 3'b010,
      BK_EMIT = 3'b100
   } back_state_type;

   back_state_type             state_ff, state_in;
   logic [cnls_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic [cnls_pkg::LEN_W-1:0] len_ff, len_in;
   logic                       trunc_ff, trunc_in;
   logic                       out_valid_ff, out_valid_in;
   cnls_pkg::rsp_payload_type  out_ff, out_in;
   logic [7:0]                 lit_mem [cnls_pkg::LIT_MAX];
   logic [7:0]                 rdata_ff;
   logic                       mem_we;
   logic                       out_free;
   logic                       run_last;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign run_last  = (cnls_pkg::LEN_W'(idx_ff) + cnls_pkg::LEN_W'(1)) == len_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_ff;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      len_in       = len_ff;
      trunc_in     = trunc_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      mem_we       = 1'b0;
      pop          = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!queue_empty) begin
               unique case (head_cmd.op)
                  cnls_pkg::CMD_WRITE: begin
                     mem_we = 1'b1;
                     pop    = 1'b1;
                  end
                  cnls_pkg::CMD_FLUSH: begin
                     len_in   = head_cmd.addr;
                     trunc_in = head_cmd.trunc;
                     idx_in   = '0;
                     state_in = BK_READ;
                     pop      = 1'b1;
                  end
                  cnls_pkg::CMD_ERROR: begin
                     if (out_free) begin
                        out_valid_in     = 1'b1;
                        out_in.out_byte  = head_cmd.data;
                        out_in.kind      = cnls_pkg::KIND_ERROR;
                        out_in.last      = 1'b1;
                        out_in.truncated = 1'b0;
                        pop              = 1'b1;
                     end
                  end
                  default: begin
                     pop = 1'b1;
                  end
               endcase
            end
         end
         BK_READ: begin
            state_in = BK_EMIT;
         end
         BK_EMIT: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_in.out_byte  = rdata_ff;
               out_in.kind      = cnls_pkg::KIND_LITERAL;
               out_in.last      = run_last;
               out_in.truncated = trunc_ff;
               if (run_last) begin
                  state_in = BK_IDLE;
               end else begin
                  idx_in   = idx_ff + cnls_pkg::IDX_W'(1);
                  state_in = BK_READ;
               end
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Literal buffer: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         lit_mem[head_cmd.addr[cnls_pkg::IDX_W-1:0]] <= head_cmd.data;
      end
      rdata_ff <= lit_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      len_ff   <= len_in;
      trunc_ff <= trunc_in;
      out_ff   <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   `CNLS_ASSERT_NOW(a_idx_in_run, state_ff != BK_IDLE, cnls_pkg::LEN_W'(idx_ff) < len_ff, "replay index beyond run length")
   `CNLS_ASSERT_NEXT(a_read_then_emit, state_ff == BK_READ, state_ff == BK_EMIT, "buffer read not followed by emit")
   `CNLS_ASSERT_NEXT(a_run_ends_idle, state_ff == BK_EMIT && out_free && run_last, state_ff == BK_IDLE, "run did not end after last word")
   `CNLS_ASSERT_NOW(a_error_shape, out_valid_ff && out_ff.kind == cnls_pkg::KIND_ERROR, out_ff.last && !out_ff.truncated, "error word must be last and untruncated")

endmodule
